// ----- rtl/pal_pkg.sv -----
package pal_pkg;

  localparam int CAPACITY_DEF = 8;

  typedef enum logic [1:0] {
    REQ_QUERY,
    REQ_INSERT,
    REQ_REMOVE,
    REQ_CLEAR
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] code;
    logic        [31:0] price;
  } entry_t;

endpackage

// ----- rtl/pal_store.sv -----
module pal_store #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
  parameter int SW       = $clog2(CAPACITY)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            ren,
  input  logic [SW-1:0]   raddr,
  output pal_pkg::entry_t rdata,
  input  logic            wen,
  input  logic [SW-1:0]   waddr,
  input  pal_pkg::entry_t wdata
);
  import pal_pkg::*;

  entry_t              mem [CAPACITY];
  logic [CAPACITY-1:0] valid;
  entry_t              rd_q;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rd_q   <= mem[raddr];
      rd_vld <= valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wen) begin
      valid[waddr] <= 1'b1;
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

// ----- rtl/pal_ctrl.sv -----
module pal_ctrl #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
  parameter int SW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [7:0]         position,
  input  logic signed [31:0] item_code,
  input  logic [31:0]        item_price,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] out_code,
  output logic [31:0]        out_price,
  output logic [3:0]         entry_count,
  output logic [2:0]         first_slot,
  output logic               ren,
  output logic [SW-1:0]      raddr,
  input  pal_pkg::entry_t    rdata,
  output logic               wen,
  output logic [SW-1:0]      waddr,
  output pal_pkg::entry_t    wdata
);
  import pal_pkg::*;

  localparam int XW = ((SW > 8) ? SW : 8) + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDWAIT,
    S_SHIFT,
    S_FINAL
  } state_t;

  state_t        state;
  logic [SW-1:0] head;
  logic [SW-1:0] head_nx;
  logic [SW-1:0] rptr;
  logic [SW-1:0] rd_addr_q;
  logic [SW-1:0] fslot;
  logic [CW-1:0] count;
  logic [CW-1:0] cnt_nx;
  logic [CW-1:0] rem;
  logic          dir_up;
  logic          rd_pend;
  logic          rd_skip;
  logic          cap_next;
  entry_t        fdata;
  entry_t        res;
  status_t       res_st;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] head_x;
  logic [XW-1:0] slot_x;
  logic [XW-1:0] last_x;
  logic          pos_ok;
  logic          ins_ok;
  logic          full;
  logic          at_end;
  logic          accept;

  always_comb begin
    pos_x  = XW'(position);
    cnt_x  = XW'(count);
    head_x = XW'(head);
    slot_x = head_x + pos_x - XW'(1);
    last_x = head_x + cnt_x - XW'(1);
    pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
    ins_ok = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
    full   = cnt_x >= XW'(CAPACITY);
    at_end = (head_x + cnt_x) >= XW'(CAPACITY);
  end

  assign accept = (state == S_IDLE) && start;
  assign busy   = (state != S_IDLE);

  assign ren   = (accept && (req_t'(req_type) == REQ_QUERY) && pos_ok) ||
                 ((state == S_SHIFT) && (rem != '0));
  assign raddr = (state == S_IDLE) ? SW'(slot_x) : rptr;
  assign wen   = ((state == S_SHIFT) && rd_pend && !rd_skip) || (state == S_FINAL);
  assign waddr = (state == S_FINAL) ? fslot :
                 (dir_up ? rd_addr_q - SW'(1) : rd_addr_q + SW'(1));
  assign wdata = (state == S_FINAL) ? fdata : rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      head    <= '0;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            res <= '0;
            unique case (req_t'(req_type))
              REQ_QUERY: begin
                if (pos_ok) begin
                  state <= S_RDWAIT;
                end else begin
                  res_st <= ST_BAD;
                  done   <= 1'b1;
                end
              end
              REQ_INSERT: begin
                if (full) begin
                  res_st <= ST_FULL;
                  done   <= 1'b1;
                end else if (!ins_ok) begin
                  res_st <= ST_BAD;
                  done   <= 1'b1;
                end else begin
                  state    <= S_SHIFT;
                  cap_next <= 1'b0;
                  fdata    <= '{code: item_code, price: item_price};
                  cnt_nx   <= count + CW'(1);
                  if (count == '0) begin
                    rem     <= '0;
                    head_nx <= '0;
                    fslot   <= '0;
                  end else if (!at_end) begin
                    rptr    <= SW'(last_x);
                    dir_up  <= 1'b0;
                    rem     <= CW'(cnt_x - pos_x + XW'(1));
                    head_nx <= head;
                    fslot   <= SW'(slot_x);
                  end else begin
                    rptr    <= head;
                    dir_up  <= 1'b1;
                    rem     <= CW'(pos_x - XW'(1));
                    head_nx <= head - SW'(1);
                    fslot   <= SW'(slot_x - XW'(1));
                  end
                end
              end
              REQ_REMOVE: begin
                if (!pos_ok) begin
                  res_st <= ST_BAD;
                  done   <= 1'b1;
                end else begin
                  state    <= S_SHIFT;
                  rptr     <= SW'(slot_x);
                  dir_up   <= 1'b1;
                  rem      <= CW'(cnt_x - pos_x + XW'(1));
                  cap_next <= 1'b1;
                  fslot    <= SW'(last_x);
                  fdata    <= '0;
                  cnt_nx   <= count - CW'(1);
                  head_nx  <= (count == CW'(1)) ? '0 : head;
                end
              end
              REQ_CLEAR: begin
                head   <= '0;
                count  <= '0;
                res_st <= ST_OK;
                done   <= 1'b1;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          res    <= rdata;
          res_st <= ST_OK;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_SHIFT: begin
          if (rd_pend && rd_skip) begin
            res <= rdata;
          end
          if (rem != '0) begin
            rptr      <= dir_up ? rptr + SW'(1) : rptr - SW'(1);
            rem       <= rem - CW'(1);
            rd_addr_q <= rptr;
            rd_skip   <= cap_next;
            cap_next  <= 1'b0;
            rd_pend   <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state   <= S_FINAL;
          end
        end
        S_FINAL: begin
          head   <= head_nx;
          count  <= cnt_nx;
          res_st <= ST_OK;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
      endcase
    end
  end

  assign status      = res_st;
  assign out_code    = res.code;
  assign out_price   = res.price;
  assign entry_count = 4'(count);
  assign first_slot  = 3'(head);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    ren && wen |-> raddr != waddr)
    else $error("read and write hit the same slot");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == '0)
    else $error("empty list with nonzero head");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && res_st != ST_OK |-> res == '0)
    else $error("error beat carries data");

  a_accept_resp: assert property (@(posedge clk) disable iff (rst)
    accept |=> done || busy)
    else $error("accepted beat dropped");

endmodule

// ----- rtl/positional_array_list_core.sv -----
// Query: slot read on accept, result registered from it; error, clear: at accept.
// Insert/remove: the shift reads at most CAPACITY slots;
// remove also reads the removed entry. One read port: one slot per cycle.
// One beat in flight; busy stays high until its done beat. done pulses one cycle.
// rst (synchronous) empties the list and makes every slot read as zero.
module positional_array_list_core #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [7:0]         position,
  input  logic signed [31:0] item_code,
  input  logic [31:0]        item_price,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] out_code,
  output logic [31:0]        out_price,
  output logic [3:0]         entry_count,
  output logic [2:0]         first_slot
);
  import pal_pkg::*;

  localparam int SW = $clog2(CAPACITY);

  logic          ren;
  logic [SW-1:0] raddr;
  entry_t        rdata;
  logic          wen;
  logic [SW-1:0] waddr;
  entry_t        wdata;

  pal_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .position    (position),
    .item_code   (item_code),
    .item_price  (item_price),
    .done        (done),
    .status      (status),
    .out_code    (out_code),
    .out_price   (out_price),
    .entry_count (entry_count),
    .first_slot  (first_slot),
    .ren         (ren),
    .raddr       (raddr),
    .rdata       (rdata),
    .wen         (wen),
    .waddr       (waddr),
    .wdata       (wdata)
  );

  pal_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .ren   (ren),
    .raddr (raddr),
    .rdata (rdata),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import pal_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  typedef struct packed {
    req_t               op;
    logic [7:0]         pos;
    logic signed [31:0] code;
    logic [31:0]        price;
  } list_req_t;

  typedef struct packed {
    status_t            st;
    logic signed [31:0] code;
    logic [31:0]        price;
    logic [3:0]         cnt;
    logic [2:0]         head;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type = REQ_QUERY;
  logic [7:0]         position = '0;
  logic signed [31:0] item_code = '0;
  logic [31:0]        item_price = '0;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] out_code;
  logic [31:0]        out_price;
  logic [3:0]         entry_count;
  logic [2:0]         first_slot;

  positional_array_list_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .position(position),
    .item_code(item_code),
    .item_price(item_price),
    .done(done),
    .status(status),
    .out_code(out_code),
    .out_price(out_price),
    .entry_count(entry_count),
    .first_slot(first_slot)
  );

  always #1 clk = ~clk;

  // shadow list
  entry_t slots [CAP];
  int     list_head = 0;
  int     list_count = 0;

  list_req_t    req_backlog [$];
  list_result_t predicted_results [$];
  list_req_t    beat;
  list_result_t want;
  int           sender_idle = 13;
  int           beats_queued = 0;
  int           beats_taken = 0;
  int           mismatch_count = 0;
  logic         taken = 1'b0;

  function automatic list_result_t apply_request(list_req_t r);
    list_result_t res;
    int p, s, last, i;
    res = '0;
    res.st = ST_OK;
    p = r.pos;
    case (r.op)
      REQ_QUERY: begin
        if (list_count == 0 || p < 1 || p > list_count) begin
          res.st = ST_BAD;
        end else begin
          s = list_head + p - 1;
          res.code = slots[s].code;
          res.price = slots[s].price;
        end
      end
      REQ_INSERT: begin
        if (list_count >= CAP) begin
          res.st = ST_FULL;
        end else if (p < 1 || p > list_count + 1) begin
          res.st = ST_BAD;
        end else begin
          if (list_count == 0) begin
            list_head = 0;
          end else if (list_head + list_count < CAP) begin
            for (i = list_head + list_count; i > list_head + p - 1; i--)
              slots[i] = slots[i - 1];
          end else begin
            for (i = list_head; i + 1 < list_head + p; i++)
              slots[i - 1] = slots[i];
            list_head--;
          end
          list_count++;
          s = list_head + p - 1;
          slots[s] = {r.code, r.price};
        end
      end
      REQ_REMOVE: begin
        if (list_count == 0 || p < 1 || p > list_count) begin
          res.st = ST_BAD;
        end else begin
          s = list_head + p - 1;
          last = list_head + list_count - 1;
          res.code = slots[s].code;
          res.price = slots[s].price;
          for (i = s; i < last; i++)
            slots[i] = slots[i + 1];
          slots[last] = '0;
          list_count--;
          if (list_count == 0)
            list_head = 0;
        end
      end
      default: begin
        list_head = 0;
        list_count = 0;
      end
    endcase
    res.cnt = list_count[3:0];
    res.head = list_head[2:0];
    return res;
  endfunction

  task automatic queue_request(req_t op, logic [7:0] pos, logic signed [31:0] code,
                               logic [31:0] price);
    list_req_t r;
    r.op = op;
    r.pos = pos;
    r.code = code;
    r.price = price;
    predicted_results.push_back(apply_request(r));
    req_backlog.push_back(r);
    beats_queued++;
  endtask

  task automatic drain();
    while (beats_taken != beats_queued || predicted_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_random(int n);
    int k, w, seg;
    bit filling;
    req_t op;
    logic [7:0] p;
    filling = 1'b0;
    seg = 0;
    for (k = 0; k < n; k++) begin
      if (seg == 0) begin
        seg = $urandom_range(15, 50);
        filling = !filling;
      end
      seg--;
      w = $urandom_range(0, 99);
      if (w < (filling ? 60 : 25)) op = REQ_INSERT;
      else if (w < (filling ? 72 : 68)) op = REQ_REMOVE;
      else if (w < 98) op = REQ_QUERY;
      else op = REQ_CLEAR;
      if ($urandom_range(0, 99) < 12) p = 8'($urandom_range(0, 255));
      else if (op == REQ_INSERT) p = 8'($urandom_range(1, list_count + 1));
      else if (list_count == 0) p = 8'd1;
      else p = 8'($urandom_range(1, list_count));
      queue_request(op, p, $urandom, $urandom);
    end
  endtask

  // hold start until the beat is taken, then advance
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (req_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle) begin
        beat = req_backlog.pop_front();
        start <= 1'b1;
        req_type <= beat.op;
        position <= beat.pos;
        item_code <= beat.code;
        item_price <= beat.price;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (start && !busy)
        beats_taken <= beats_taken + 1;
      if (done) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with nothing outstanding");
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            mismatch_count++;
          end
          if (out_code !== want.code) begin
            $error("out_code: expected %0d, got %0d", want.code, out_code);
            mismatch_count++;
          end
          if (out_price !== want.price) begin
            $error("out_price: expected %0h, got %0h", want.price, out_price);
            mismatch_count++;
          end
          if (entry_count !== want.cnt) begin
            $error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
            mismatch_count++;
          end
          if (first_slot !== want.head) begin
            $error("first_slot: expected %0d, got %0d", want.head, first_slot);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("positional_array_list_core verification failed");
    $finish;
  end

  initial begin
    int k;
    for (k = 0; k < CAP; k++)
      slots[k] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_idle = 13;
    queue_request(REQ_QUERY, 8'd1, $urandom, $urandom);
    queue_request(REQ_REMOVE, 8'd1, $urandom, $urandom);
    queue_request(REQ_INSERT, 8'd0, $urandom, $urandom);
    queue_request(REQ_INSERT, 8'd2, $urandom, $urandom);
    queue_request(REQ_INSERT, 8'd1, 32'sh8000_0000, 32'h0000_0000);
    queue_request(REQ_INSERT, 8'd1, 32'sh7fff_ffff, 32'hffff_ffff);
    queue_request(REQ_INSERT, 8'd3, -32'sd1, 32'h0000_0001);
    queue_request(REQ_INSERT, 8'd2, $urandom, $urandom);
    while (list_count < CAP)
      queue_request(REQ_INSERT, 8'($urandom_range(1, list_count + 1)), $urandom, $urandom);
    queue_request(REQ_INSERT, 8'd1, $urandom, $urandom);
    queue_request(REQ_INSERT, 8'd0, $urandom, $urandom);
    queue_request(REQ_QUERY, 8'd0, $urandom, $urandom);
    queue_request(REQ_QUERY, 8'd255, $urandom, $urandom);
    queue_request(REQ_QUERY, 8'd8, $urandom, $urandom);
    queue_request(REQ_QUERY, 8'd9, $urandom, $urandom);
    queue_request(REQ_REMOVE, 8'd8, $urandom, $urandom);
    queue_request(REQ_REMOVE, 8'd3, $urandom, $urandom);
    queue_request(REQ_REMOVE, 8'd1, $urandom, $urandom);
    queue_request(REQ_INSERT, 8'd255, $urandom, $urandom);
    queue_request(REQ_CLEAR, 8'd0, $urandom, $urandom);
    queue_request(REQ_QUERY, 8'd1, $urandom, $urandom);
    queue_request(REQ_INSERT, 8'd1, $urandom, $urandom);
    queue_request(REQ_REMOVE, 8'd1, $urandom, $urandom);
    drain();

    queue_random(650);
    drain();

    sender_idle = 57;
    queue_random(650);
    drain();

    sender_idle = 0;
    queue_random(650);
    drain();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("positional_array_list_core verification clean");
    else
      $display("positional_array_list_core verification failed");
    $finish;
  end

endmodule

// ----- positional_array_list_core.f -----
rtl/pal_pkg.sv
rtl/pal_store.sv
rtl/pal_ctrl.sv
rtl/positional_array_list_core.sv
verif/tb.sv
